@@ rtl/core/ttik_pkg.sv @@
// Shared constants, register codes and the CORDIC arctangent table for the
// tool tip inverse kinematics block. No dependencies.
package ttik_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_ANGLE_WIDTH = 32;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int PIPE_LAT     = CORDIC_LAT + 9;

    localparam int SC_W = 32;   // sine/cosine, Q2.30
    localparam int CZ_W = 34;   // CORDIC datapath

    localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CZ_W-1:0] ONE_Q30     = 34'sd1073741824;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_TWIST_FIRST   = 3'd0;
    localparam t_cfg_idx REG_TWIST_SECOND  = 3'd1;
    localparam t_cfg_idx REG_LENGTH_FIRST  = 3'd2;
    localparam t_cfg_idx REG_LENGTH_SECOND = 3'd3;
    localparam t_cfg_idx REG_OFFSET_FIRST  = 3'd4;
    localparam t_cfg_idx REG_OFFSET_SECOND = 3'd5;

    function automatic logic signed [CZ_W-1:0] atan_val(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sh20000000;
            5'd1:  v = 34'sh12E4051E;
            5'd2:  v = 34'sh09FB385B;
            5'd3:  v = 34'sh051111D4;
            5'd4:  v = 34'sh028B0D43;
            5'd5:  v = 34'sh0145D7E1;
            5'd6:  v = 34'sh00A2F61E;
            5'd7:  v = 34'sh00517C55;
            5'd8:  v = 34'sh0028BE53;
            5'd9:  v = 34'sh00145F2F;
            5'd10: v = 34'sh000A2F98;
            5'd11: v = 34'sh000517CC;
            5'd12: v = 34'sh00028BE6;
            5'd13: v = 34'sh000145F3;
            5'd14: v = 34'sh0000A2FA;
            5'd15: v = 34'sh0000517D;
            5'd16: v = 34'sh000028BE;
            5'd17: v = 34'sh0000145F;
            5'd18: v = 34'sh00000A30;
            5'd19: v = 34'sh00000518;
            5'd20: v = 34'sh0000028C;
            5'd21: v = 34'sh00000146;
            5'd22: v = 34'sh000000A3;
            5'd23: v = 34'sh00000051;
            5'd24: v = 34'sh00000029;
            5'd25: v = 34'sh00000014;
            5'd26: v = 34'sh0000000A;
            5'd27: v = 34'sh00000005;
            5'd28: v = 34'sh00000003;
            5'd29: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/ttik_cordic.sv @@
// Pipelined circular CORDIC: binary angle in, Q2.30 sine and cosine out,
// one stage per iteration. Depends on ttik_pkg.
module ttik_cordic import ttik_pkg::*; #(
    parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [SC_W-1:0] o_sin,
    output logic signed [SC_W-1:0] o_cos
);

    logic signed [CZ_W-1:0] r_x [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_y [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_z [0:CORDIC_STEPS];
    logic                   r_flip [0:CORDIC_STEPS];
    logic signed [SC_W-1:0] r_sin, r_cos;

    logic [31:0] a32, a_rot, a_f;
    logic        flip;
    logic signed [CZ_W-1:0] n_xc, n_yc;

    always_comb begin
        a32   = 32'(i_angle) << (32 - ANGLE_WIDTH);
        a_rot = a32 + 32'h4000_0000;
        flip  = a_rot[31];
        a_f   = a32 ^ {flip, 31'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= CZ_W'(signed'(a_f));
            r_flip[0] <= flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i][CZ_W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_val(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_val(5'(i));
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_comb begin
        n_xc = r_x[CORDIC_STEPS];
        n_yc = r_y[CORDIC_STEPS];
        if (n_xc > ONE_Q30)  n_xc = ONE_Q30;
        if (n_xc < -ONE_Q30) n_xc = -ONE_Q30;
        if (n_yc > ONE_Q30)  n_yc = ONE_Q30;
        if (n_yc < -ONE_Q30) n_yc = -ONE_Q30;
        if (r_flip[CORDIC_STEPS]) begin
            n_xc = -n_xc;
            n_yc = -n_yc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= SC_W'(n_yc);
            r_cos <= SC_W'(n_xc);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ rtl/core/ttik_mulq.sv @@
// Length times Q2.30 sine/cosine, rounded to Q.16 with ties up. Products
// are registered; the rounding add follows the register. Depends on ttik_pkg.
module ttik_mulq import ttik_pkg::*; #(
    parameter int IW = 40
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IW-1:0]   i_v,
    input  logic signed [SC_W-1:0] i_s,
    output logic signed [IW-1:0]   o_r
);

    localparam int HW  = IW - 30;
    localparam int PHW = HW + SC_W;
    localparam int PLW = 31 + SC_W;
    localparam logic signed [PLW-1:0] HALF = PLW'(1) << 29;

    logic signed [HW-1:0]  hi;
    logic signed [30:0]    lo;
    logic signed [PHW-1:0] r_ph;
    logic signed [PLW-1:0] r_plo;
    logic signed [PLW-1:0] rnd;

    assign hi = i_v[IW-1:30];
    assign lo = {1'b0, i_v[29:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph  <= hi * i_s;
            r_plo <= lo * i_s;
        end
    end

    assign rnd = (r_plo + HALF) >>> 30;
    assign o_r = IW'(r_ph) + IW'(rnd);

endmodule

@@ rtl/core/tool_tip_inverse_kinematics.sv @@
// Top level: tool tip to linear axis inverse kinematics for a head-head
// five-axis machine. Depends on ttik_pkg, ttik_cordic and ttik_mulq.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_ready   angles, tool offset, tip
//   out       source     o_out_valid / i_out_ready axis x/y/z, overflow
//   cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle unless output stalls, via the CORDIC lanes, four
// multiply/sum levels and saturation. The whole pipeline advances while
// the output register is empty or taken, so a stall holds every stage.
// Reset clears the valid bits and the link registers; cfg is always ready.
module tool_tip_inverse_kinematics import ttik_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_first,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_second,
    input  logic signed [COORD_WIDTH-1:0] i_tool_off_x,
    input  logic signed [COORD_WIDTH-1:0] i_tool_off_y,
    input  logic signed [COORD_WIDTH-1:0] i_tool_off_z,
    input  logic signed [COORD_WIDTH-1:0] i_tip_x,
    input  logic signed [COORD_WIDTH-1:0] i_tip_y,
    input  logic signed [COORD_WIDTH-1:0] i_tip_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_axis_x,
    output logic signed [COORD_WIDTH-1:0] o_axis_y,
    output logic signed [COORD_WIDTH-1:0] o_axis_z,
    output logic                          o_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  t_cfg_idx                      i_cfg_index,
    input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = (CW + 8 > 32) ? CW + 8 : 32;
    localparam int NSLOT = 16;
    localparam logic signed [IW-1:0] MAXV = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [IW-1:0] MINV = ~MAXV;

    typedef struct packed {
        logic signed [CW-1:0] tx, ty, tz, px, py, pz;
    } t_tin;

    typedef struct packed {
        logic signed [IW-1:0]   e, u, c, a, b, d, x, y, z, px, py, pz;
        logic signed [SC_W-1:0] s1, c1, s2, c2;
    } t_pipe;

    logic adv, accept;
    logic r_vld [0:PIPE_LAT-1];
    t_tin  r_tin [0:CORDIC_LAT-1];
    t_pipe r_pl [1:8];
    t_pipe n_pl [1:8];

    logic [ANGLE_WIDTH-1:0]  r_tw1, r_tw2;
    logic signed [CW-1:0]    r_l1, r_l2, r_d1, r_d2;

    logic signed [SC_W-1:0] sa1, ca1, sa2, ca2, s1, c1, s2, c2;
    logic signed [IW-1:0]   m_v [0:NSLOT-1];
    logic signed [SC_W-1:0] m_s [0:NSLOT-1];
    logic signed [IW-1:0]   m_r [0:NSLOT-1];

    logic signed [IW-1:0]   n_x, n_y, n_z;
    logic                   n_ox, n_oy, n_oz;
    logic signed [CW-1:0]   r_ox, r_oy, r_oz;
    logic                   r_ovf;

    assign adv         = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign accept      = i_in_valid && adv;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw1 <= '0;
            r_tw2 <= '0;
            r_l1  <= '0;
            r_l2  <= '0;
            r_d1  <= '0;
            r_d2  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TWIST_FIRST:   r_tw1 <= i_cfg_data[ANGLE_WIDTH-1:0];
                REG_TWIST_SECOND:  r_tw2 <= i_cfg_data[ANGLE_WIDTH-1:0];
                REG_LENGTH_FIRST:  r_l1  <= i_cfg_data[CW-1:0];
                REG_LENGTH_SECOND: r_l2  <= i_cfg_data[CW-1:0];
                REG_OFFSET_FIRST:  r_d1  <= i_cfg_data[CW-1:0];
                REG_OFFSET_SECOND: r_d2  <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= accept;
            for (int k = 1; k < PIPE_LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // twist lanes run from the static link registers alongside each item
    ttik_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_tw1 (
        .i_clk(i_clk), .i_en(adv), .i_angle(r_tw1), .o_sin(sa1), .o_cos(ca1));
    ttik_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_tw2 (
        .i_clk(i_clk), .i_en(adv), .i_angle(r_tw2), .o_sin(sa2), .o_cos(ca2));
    ttik_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_q1 (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_first), .o_sin(s1), .o_cos(c1));
    ttik_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_q2 (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_second), .o_sin(s2), .o_cos(c2));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tin[0] <= '{tx: i_tool_off_x, ty: i_tool_off_y, tz: i_tool_off_z,
                          px: i_tip_x, py: i_tip_y, pz: i_tip_z};
            for (int k = 1; k < CORDIC_LAT; k++) r_tin[k] <= r_tin[k-1];
        end
    end

    for (genvar g = 0; g < NSLOT; g++) begin : g_mul
        ttik_mulq #(.IW(IW)) u_mulq (
            .i_clk(i_clk), .i_en(adv), .i_v(m_v[g]), .i_s(m_s[g]), .o_r(m_r[g]));
    end

    // multiplier operands per level
    always_comb begin
        m_v[0]  = IW'(r_tin[CORDIC_LAT-1].ty);  m_s[0]  = ca1;
        m_v[1]  = IW'(r_tin[CORDIC_LAT-1].tz);  m_s[1]  = sa1;
        m_v[2]  = IW'(r_tin[CORDIC_LAT-1].tz);  m_s[2]  = ca1;
        m_v[3]  = IW'(r_tin[CORDIC_LAT-1].ty);  m_s[3]  = sa1;
        m_v[4]  = r_pl[2].u;  m_s[4]  = r_pl[2].s1;
        m_v[5]  = r_pl[2].e;  m_s[5]  = r_pl[2].c1;
        m_v[6]  = r_pl[2].u;  m_s[6]  = r_pl[2].c1;
        m_v[7]  = r_pl[2].e;  m_s[7]  = r_pl[2].s1;
        m_v[8]  = r_pl[4].b;  m_s[8]  = ca2;
        m_v[9]  = r_pl[4].c;  m_s[9]  = sa2;
        m_v[10] = r_pl[4].b;  m_s[10] = sa2;
        m_v[11] = r_pl[4].c;  m_s[11] = ca2;
        m_v[12] = r_pl[6].a;  m_s[12] = r_pl[6].c2;
        m_v[13] = r_pl[6].d;  m_s[13] = r_pl[6].s2;
        m_v[14] = r_pl[6].a;  m_s[14] = r_pl[6].s2;
        m_v[15] = r_pl[6].d;  m_s[15] = r_pl[6].c2;
    end

    always_comb begin
        n_pl[1]    = '0;
        n_pl[1].e  = IW'(r_tin[CORDIC_LAT-1].tx) - IW'(r_l1);
        n_pl[1].px = IW'(r_tin[CORDIC_LAT-1].px);
        n_pl[1].py = IW'(r_tin[CORDIC_LAT-1].py);
        n_pl[1].pz = IW'(r_tin[CORDIC_LAT-1].pz);
        n_pl[1].s1 = s1;
        n_pl[1].c1 = c1;
        n_pl[1].s2 = s2;
        n_pl[1].c2 = c2;

        n_pl[2]   = r_pl[1];
        n_pl[2].u = m_r[0] + m_r[1];
        n_pl[2].c = m_r[2] - m_r[3] - IW'(r_d1);

        n_pl[3] = r_pl[2];

        n_pl[4]   = r_pl[3];
        n_pl[4].a = m_r[4] + m_r[5] - IW'(r_l2);
        n_pl[4].b = m_r[6] - m_r[7];

        n_pl[5] = r_pl[4];

        n_pl[6]   = r_pl[5];
        n_pl[6].d = m_r[8] + m_r[9];
        n_pl[6].z = r_pl[5].pz + IW'(r_d2) + m_r[10] - m_r[11];

        n_pl[7] = r_pl[6];

        n_pl[8]   = r_pl[7];
        n_pl[8].x = r_pl[7].px - m_r[12] - m_r[13];
        n_pl[8].y = r_pl[7].py + m_r[14] - m_r[15];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 1; k <= 8; k++) r_pl[k] <= n_pl[k];
        end
    end

    always_comb begin
        n_x = r_pl[8].x;
        n_y = r_pl[8].y;
        n_z = r_pl[8].z;
        n_ox = (n_x > MAXV) || (n_x < MINV);
        n_oy = (n_y > MAXV) || (n_y < MINV);
        n_oz = (n_z > MAXV) || (n_z < MINV);
        if (n_x > MAXV) n_x = MAXV;
        if (n_x < MINV) n_x = MINV;
        if (n_y > MAXV) n_y = MAXV;
        if (n_y < MINV) n_y = MINV;
        if (n_z > MAXV) n_z = MAXV;
        if (n_z < MINV) n_z = MINV;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox  <= CW'(n_x);
            r_oy  <= CW'(n_y);
            r_oz  <= CW'(n_z);
            r_ovf <= n_ox || n_oy || n_oz;
        end
    end

    assign o_out_valid = r_vld[PIPE_LAT-1];
    assign o_axis_x    = r_ox;
    assign o_axis_y    = r_oy;
    assign o_axis_z    = r_oz;
    assign o_overflow  = r_ovf;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("item out of reset");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |->
            (o_axis_x == CW'(MAXV) || o_axis_x == CW'(MINV) ||
             o_axis_y == CW'(MAXV) || o_axis_y == CW'(MINV) ||
             o_axis_z == CW'(MAXV) || o_axis_z == CW'(MINV)))
        else $error("overflow without clamped axis");

    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[CORDIC_LAT-1] |->
            (SC_W'(ONE_Q30) >= s1 && s1 >= -SC_W'(ONE_Q30) &&
             SC_W'(ONE_Q30) >= c2 && c2 >= -SC_W'(ONE_Q30)))
        else $error("sine/cosine out of range");

endmodule

@@ verif/ttik_checker.sv @@
// Scoreboard for tool_tip_inverse_kinematics: mirrors the link registers and
// predicts the axis positions of each accepted point. Depends on ttik_pkg.
`timescale 1ns / 100ps

module ttik_checker import ttik_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_angle_first,
    input  logic [31:0] i_angle_second,
    input  logic [31:0] i_tool_off_x,
    input  logic [31:0] i_tool_off_y,
    input  logic [31:0] i_tool_off_z,
    input  logic [31:0] i_tip_x,
    input  logic [31:0] i_tip_y,
    input  logic [31:0] i_tip_z,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_axis_x,
    input  logic [31:0] i_axis_y,
    input  logic [31:0] i_axis_z,
    input  logic        i_overflow,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_ovf_seen
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        ovf;
    } t_axes;

    localparam longint ARCTAN [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic [31:0] link_reg [6];
    t_axes       axes_due [$];

    function automatic void sin_cos(input logic [31:0] a, output longint sn, output longint cs);
        logic   flip;
        longint x, y, z, dx, dy;
        flip = ((a + 32'h4000_0000) >= 32'h8000_0000);
        if (flip) begin
            a = a ^ 32'h8000_0000;
        end
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ARCTAN[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ARCTAN[i];
            end
        end
        if (x > 1073741824) x = 1073741824;
        if (x < -1073741824) x = -1073741824;
        if (y > 1073741824) y = 1073741824;
        if (y < -1073741824) y = -1073741824;
        if (flip) begin
            x = -x; y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    // length times Q2.30 trig value, rounded to Q.16 with ties upward
    function automatic longint scale_q30(input longint v, input longint s);
        longint lo, hi;
        lo = v & 64'h3FFF_FFFF;
        hi = v >>> 30;
        return hi * s + ((lo * s + 64'sh2000_0000) >>> 30);
    endfunction

    function automatic logic [31:0] clamp_axis(input longint v, inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_axes solve_axes(input logic [31:0] q1, input logic [31:0] q2,
                                         input longint tx, input longint ty, input longint tz,
                                         input longint px, input longint py, input longint pz);
        longint sa1, ca1, sa2, ca2, s1, c1, s2, c2;
        longint l1, l2, d1, d2, u, e, a, b, c, d;
        t_axes  r;
        l1 = longint'($signed(link_reg[REG_LENGTH_FIRST]));
        l2 = longint'($signed(link_reg[REG_LENGTH_SECOND]));
        d1 = longint'($signed(link_reg[REG_OFFSET_FIRST]));
        d2 = longint'($signed(link_reg[REG_OFFSET_SECOND]));
        sin_cos(link_reg[REG_TWIST_FIRST], sa1, ca1);
        sin_cos(link_reg[REG_TWIST_SECOND], sa2, ca2);
        sin_cos(q1, s1, c1);
        sin_cos(q2, s2, c2);
        u = scale_q30(ty, ca1) + scale_q30(tz, sa1);
        e = tx - l1;
        a = scale_q30(u, s1) + scale_q30(e, c1) - l2;
        b = scale_q30(u, c1) - scale_q30(e, s1);
        c = scale_q30(tz, ca1) - scale_q30(ty, sa1) - d1;
        d = scale_q30(b, ca2) + scale_q30(c, sa2);
        r.ovf = 1'b0;
        r.x = clamp_axis(px - scale_q30(a, c2) - scale_q30(d, s2), r.ovf);
        r.y = clamp_axis(py + scale_q30(a, s2) - scale_q30(d, c2), r.ovf);
        r.z = clamp_axis(pz + d2 + scale_q30(b, sa2) - scale_q30(c, ca2), r.ovf);
        return r;
    endfunction

    assign o_pending = axes_due.size();

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_ovf_seen   = 0;
        foreach (link_reg[i]) link_reg[i] = '0;
    end

    always @(posedge i_clk) begin
        t_axes want;
        if (!i_rst_n) begin
            foreach (link_reg[i]) link_reg[i] <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= REG_OFFSET_SECOND) begin
                link_reg[i_cfg_index] <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                axes_due.push_back(solve_axes(i_angle_first, i_angle_second,
                    longint'($signed(i_tool_off_x)), longint'($signed(i_tool_off_y)),
                    longint'($signed(i_tool_off_z)), longint'($signed(i_tip_x)),
                    longint'($signed(i_tip_y)), longint'($signed(i_tip_z))));
            end
            if (i_out_valid && i_out_ready) begin
                if (axes_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected item x=%h y=%h z=%h ovf=%b",
                                 i_axis_x, i_axis_y, i_axis_z, i_overflow);
                end else begin
                    want = axes_due.pop_front();
                    o_checked++;
                    if (i_overflow) o_ovf_seen++;
                    if (want.x !== i_axis_x || want.y !== i_axis_y ||
                        want.z !== i_axis_z || want.ovf !== i_overflow) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: item %0d exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                                     o_checked, want.x, want.y, want.z, want.ovf,
                                     i_axis_x, i_axis_y, i_axis_z, i_overflow);
                    end
                end
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
// Top of the tool_tip_inverse_kinematics bench: clock, reset, register
// phases, point stimulus and verdict. Depends on ttik_pkg, ttik_checker and the DUT.
`timescale 1ns / 100ps

module testbench;
    import ttik_pkg::*;

    localparam t_cfg_idx REG_SPARE_LOW  = 3'd6;
    localparam t_cfg_idx REG_SPARE_HIGH = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 300;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [31:0] i_angle_first, i_angle_second;
    logic [31:0] i_tool_off_x, i_tool_off_y, i_tool_off_z;
    logic [31:0] i_tip_x, i_tip_y, i_tip_z;
    logic        o_out_valid, i_out_ready;
    logic [31:0] o_axis_x, o_axis_y, o_axis_z;
    logic        o_overflow;
    logic        i_cfg_valid, o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_data;

    int fail_count, pending, checked, ovf_seen;
    int hold_req = 0;
    int hold_done = 0;
    bit no_idle = 0;
    int quiet = 0;

    tool_tip_inverse_kinematics DUT (.*);

    ttik_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_angle_first, .i_angle_second, .i_tool_off_x, .i_tool_off_y, .i_tool_off_z,
        .i_tip_x, .i_tip_y, .i_tip_z,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_axis_x(o_axis_x), .i_axis_y(o_axis_y), .i_axis_z(o_axis_z),
        .i_overflow(o_overflow),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked), .o_ovf_seen(ovf_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = hold_req;
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired, %0d items outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_point(input logic [31:0] q1, input logic [31:0] q2,
                              input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] tz, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz);
        if (!no_idle && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_angle_first  <= q1;
        i_angle_second <= q2;
        i_tool_off_x   <= tx;
        i_tool_off_y   <= ty;
        i_tool_off_z   <= tz;
        i_tip_x        <= px;
        i_tip_y        <= py;
        i_tip_z        <= pz;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coord_rand();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'h7FFF_FFFF, 32'h7F00_0000) ^
                            {32{1'($urandom_range(1))}};
            default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++) begin
            send_point($urandom, $urandom, coord_rand(), coord_rand(), coord_rand(),
                       coord_rand(), coord_rand(), coord_rand());
        end
    endtask

    task automatic load_links(input logic [31:0] a1, input logic [31:0] a2,
                              input logic [31:0] l1, input logic [31:0] l2,
                              input logic [31:0] d1, input logic [31:0] d2);
        write_reg(REG_TWIST_FIRST, a1);
        write_reg(REG_TWIST_SECOND, a2);
        write_reg(REG_LENGTH_FIRST, l1);
        write_reg(REG_LENGTH_SECOND, l2);
        write_reg(REG_OFFSET_FIRST, d1);
        write_reg(REG_OFFSET_SECOND, d2);
    endtask

    initial begin
        logic [31:0] ang [8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TWIST_FIRST;
        i_cfg_data = '0;
        {i_angle_first, i_angle_second, i_tool_off_x, i_tool_off_y} = '0;
        {i_tool_off_z, i_tip_x, i_tip_y, i_tip_z} = '0;
        ang = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                32'h3FFF_FFFF, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset link values, directed corners
        foreach (ang[k]) send_point(ang[k], ang[7 - k], 32'h0001_0000, 32'hFFFF_0000,
                                    32'h0002_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0);
        send_point('0, '0, '0, '0, '0, '0, '0, '0);
        send_point('1, '1, '1, '1, '1, '1, '1, '1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point('0, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_0000, 32'h8000_0000, 32'h8001_0000);
        random_points(60);
        drain();

        // extreme negative links; long receiver hold while points keep coming
        load_links(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
        hold_req <= hold_req + 1;
        random_points(90);
        drain();

        // extreme positive links, then spare indexes must be ignored
        load_links(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_reg(REG_SPARE_LOW, $urandom);
        write_reg(REG_SPARE_HIGH, $urandom);
        send_point('0, '0, '0, '0, '0, '0, '0, '0);
        random_points(70);
        drain();

        // realistic head geometry, back to back with no idling
        load_links(32'h4000_0000, 32'hC000_0000, 32'h0032_0000, 32'hFFE0_0000,
                   32'h0064_0000, 32'h0019_8000);
        no_idle = 1'b1;
        random_points(120);
        no_idle = 1'b0;
        drain();

        // fully random links
        for (int p = 0; p < 3; p++) begin
            load_links($urandom, $urandom, coord_rand(), coord_rand(), coord_rand(), coord_rand());
            random_points(50);
            drain();
        end

        $display("Checked %0d points across 7 link settings, %0d with saturation.",
                 checked, ovf_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
